[src/b32d_pkg.sv]
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and constants for the Base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='

    localparam logic ALPHABET_STD = 1'b0;
    localparam logic ALPHABET_HEX = 1'b1;

    localparam logic [2:0] PAD_COUNT_MAX = 3'd7;

    // Classification of one input character
    typedef struct packed {
        logic       skip;    // CR or LF
        logic       pad;     // '='
        logic       bad;     // not in the selected alphabet
        logic [4:0] value;   // 5-bit symbol value when a data character
    } sym_class_t;

    // Pad count expected for a given data count modulo 8
    typedef struct packed {
        logic       ok;      // data count is a legal group remainder
        logic [2:0] pads;
    } pad_rule_t;

    function automatic pad_rule_t pad_rule(input logic [2:0] count);
        pad_rule_t r;
        r = '{ok: 1'b1, pads: 3'd0};
        case (count)
            3'd0:    r.pads = 3'd0;
            3'd2:    r.pads = 3'd6;
            3'd4:    r.pads = 3'd4;
            3'd5:    r.pads = 3'd3;
            3'd7:    r.pads = 3'd1;
            default: r.ok   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[src/b32d_if.sv]
// ----------------------------------------------------------------------------
// b32d_if
// Valid/ready channels: encoded characters in, decoded results out.
// ----------------------------------------------------------------------------
interface b32d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface b32d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    logic       message_error;

    modport source (output valid, output data_byte, output byte_valid,
                    output message_end, output message_error, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input message_end, input message_error, output ready);
endinterface

[src/b32d_sym_map.sv]
// ----------------------------------------------------------------------------
// b32d_sym_map
// Character classifier: CR/LF, pad, and alphabet lookup (standard or hex).
// ----------------------------------------------------------------------------
module b32d_sym_map
(
    input  logic                   hex_sel,
    input  logic [7:0]             character,
    output b32d_pkg::sym_class_t   cls
);

    logic [7:0] offs;

    always_comb
    begin
        cls  = '{skip: 1'b0, pad: 1'b0, bad: 1'b0, value: 5'd0};
        offs = 8'd0;
        if (character == b32d_pkg::CHAR_CR || character == b32d_pkg::CHAR_LF)
        begin
            cls.skip = 1'b1;
        end
        else if (character == b32d_pkg::CHAR_PAD)
        begin
            cls.pad = 1'b1;
        end
        else if (hex_sel == b32d_pkg::ALPHABET_HEX)
        begin
            case (character) inside
                [8'h30:8'h39]: offs = character - 8'h30;            // 0-9
                [8'h41:8'h56]: offs = character - 8'h41 + 8'd10;    // A-V
                [8'h61:8'h76]: offs = character - 8'h61 + 8'd10;    // a-v
                default:       cls.bad = 1'b1;
            endcase
        end
        else
        begin
            case (character) inside
                [8'h41:8'h5A]: offs = character - 8'h41;            // A-Z
                [8'h61:8'h7A]: offs = character - 8'h61;            // a-z
                [8'h32:8'h37]: offs = character - 8'h32 + 8'd26;    // 2-7
                default:       cls.bad = 1'b1;
            endcase
        end
        cls.value = offs[4:0];
    end

endmodule

[src/base32_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base32_stream_decoder_top
// Streaming Base32 decoder, standard or extended hex alphabet.
// ----------------------------------------------------------------------------
// One character is taken per request; a new request can be accepted in
// every cycle unless stalled. The character is classified and its 5-bit value
// shifted into a 12-bit accumulator in the same cycle it is accepted; the
// result (a byte, and/or the end-of-message status) lands in an output
// register. Ready only drops while that output register holds a result the
// sink has not taken, so sustained throughput is one character per clock
// whenever the sink keeps up. Bytes leave before the message is validated:
// when message_end comes back with message_error set, drop every byte of that
// message. CR and LF are skipped; a message that carries last_char on CR/LF
// still ends there. alphabet_select (0 = A-Z 2-7, 1 = 0-9 A-V, lowercase
// accepted) must only be written while no message is in flight.
// ----------------------------------------------------------------------------
module base32_stream_decoder_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 alphabet_select_wr_en,
    input  logic                 alphabet_select_wr_data,
    b32d_char_if.sink            char_in,
    b32d_byte_if.source          byte_out
);

    // ---- configuration ----
    logic alphabet_reg;

    // ---- message state ----
    logic [11:0] acc_reg,       acc_next;
    logic [3:0]  held_reg,      held_next;
    logic [2:0]  count_reg,     count_next;
    logic [2:0]  pads_reg,      pads_next;
    logic        pad_seen_reg,  pad_seen_next;
    logic        err_reg,       err_next;

    // ---- output register ----
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        byte_valid_reg;
    logic        end_reg;
    logic        error_reg;

    // ---- per-character datapath ----
    b32d_pkg::sym_class_t  cls;
    b32d_pkg::pad_rule_t   rule;
    logic        accept;
    logic        load;
    logic        have_byte;
    logic [7:0]  byte_val;
    logic [11:0] acc_shift;
    logic [11:0] byte_window;
    logic [11:0] left_mask;
    logic [3:0]  held_sum;
    logic        end_err;

    b32d_sym_map u_sym_map
    (
        .hex_sel   (alphabet_reg),
        .character (char_in.character),
        .cls       (cls)
    );

    // Output register frees up as soon as the sink takes it
    assign char_in.ready = !out_valid_reg || byte_out.ready;
    assign accept        = char_in.valid && char_in.ready;

    assign acc_shift = {acc_reg[6:0], cls.value};
    assign held_sum  = held_reg + 4'd5;

    always_comb
    begin
        acc_next      = acc_reg;
        held_next     = held_reg;
        count_next    = count_reg;
        pads_next     = pads_reg;
        pad_seen_next = pad_seen_reg;
        err_next      = err_reg;
        have_byte     = 1'b0;
        byte_window   = 12'd0;

        if (accept && !cls.skip)
        begin
            if (cls.pad)
            begin
                pad_seen_next = 1'b1;
                if (pads_reg != b32d_pkg::PAD_COUNT_MAX)
                begin
                    pads_next = pads_reg + 3'd1;
                end
            end
            else if (cls.bad || pad_seen_reg)
            begin
                err_next = 1'b1;  // bad symbol or data after padding
            end
            else
            begin
                acc_next   = acc_shift;
                count_next = count_reg + 3'd1;
                if (held_sum >= 4'd8)
                begin
                    held_next   = held_sum - 4'd8;
                    have_byte   = 1'b1;
                    byte_window = acc_shift >> held_next[2:0];
                end
                else
                begin
                    held_next = held_sum;
                end
            end
        end

        byte_val = have_byte ? byte_window[7:0] : 8'd0;

        // End-of-message checks on the post-update state
        rule      = b32d_pkg::pad_rule(count_next);
        left_mask = ~(12'hFFF << held_next[2:0]);
        end_err   = err_next || !rule.ok
                 || (pads_next != 3'd0 && pads_next != rule.pads)
                 || ((acc_next & left_mask) != 12'd0);

        load = accept && (have_byte || char_in.last_char);

        if (accept && char_in.last_char)
        begin
            acc_next      = 12'd0;
            held_next     = 4'd0;
            count_next    = 3'd0;
            pads_next     = 3'd0;
            pad_seen_next = 1'b0;
            err_next      = 1'b0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (byte_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_reg  <= b32d_pkg::ALPHABET_STD;
            acc_reg       <= 12'd0;
            held_reg      <= 4'd0;
            count_reg     <= 3'd0;
            pads_reg      <= 3'd0;
            pad_seen_reg  <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (alphabet_select_wr_en)
            begin
                alphabet_reg <= alphabet_select_wr_data;
            end
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            pads_reg      <= pads_next;
            pad_seen_reg  <= pad_seen_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg       <= byte_val;
            byte_valid_reg <= have_byte;
            end_reg        <= char_in.last_char;
            error_reg      <= char_in.last_char && end_err;
        end
    end

    assign byte_out.valid         = out_valid_reg;
    assign byte_out.data_byte     = byte_reg;
    assign byte_out.byte_valid    = byte_valid_reg;
    assign byte_out.message_end   = end_reg;
    assign byte_out.message_error = error_reg;

endmodule

[src/b32d_checker.sv]
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks for the Base32 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32d_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       message_end,
    input  logic       message_error
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(data_byte) && $stable(byte_valid)
            && $stable(message_end) && $stable(message_error))
        else $error("result changed while stalled");

    // Every result carries a byte or an end marker
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || message_end))
        else $error("empty result");

    // Error only reported on the end marker
    a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_error |-> message_end)
        else $error("error without end");

    // No byte, zero data
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> data_byte == 8'd0)
        else $error("stray data byte");

    // Input is never held off while the output side can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled without back-pressure");

endmodule

bind base32_stream_decoder_top b32d_checker u_b32d_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (char_in.ready),
    .out_valid     (byte_out.valid),
    .out_ready     (byte_out.ready),
    .data_byte     (byte_out.data_byte),
    .byte_valid    (byte_out.byte_valid),
    .message_end   (byte_out.message_end),
    .message_error (byte_out.message_error)
);
